// ----- rtl/core/breakpoint_table_interpolator_core_macros.svh -----
// assertion macros for the breakpoint table interpolator
`ifndef BREAKPOINT_TABLE_INTERPOLATOR_CORE_MACROS_SVH
`define BREAKPOINT_TABLE_INTERPOLATOR_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BTI_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BTI_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BTI_ASSERT(label, clk, rst, prop, msg)
`define BTI_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ----- rtl/core/bti_pkg.sv -----
// ----------------------------------------------------------------------------
// bti_pkg
// types and constants shared by the breakpoint table interpolator
// ----------------------------------------------------------------------------
package bti_pkg;
  localparam int DefTableDepth = 256;
  localparam int ValW = 32;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_INS_RD, S_INS_CMP, S_INS_WR, S_SRCH_RD, S_SRCH_CMP,
    S_FETCH, S_FETCH_W, S_MUL, S_DIV, S_DONE, S_OUT
  } state_t;

  // divider handshake
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;
endpackage

// ----- rtl/core/bti_if.sv -----
// ----------------------------------------------------------------------------
// bti_in_if / bti_out_if / bti_cfg_if
// valid-ready channels of the interpolator
// ----------------------------------------------------------------------------
interface bti_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic signed [31:0] in_x;
  logic signed [31:0] in_y;
  modport source (output valid, cmd, in_x, in_y, input ready);
  modport sink   (input valid, cmd, in_x, in_y, output ready);
endinterface

interface bti_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic [1:0]         status;
  modport source (output valid, result_value, status, input ready);
  modport sink   (input valid, result_value, status, output ready);
endinterface

interface bti_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/core/bti_divider.sv -----
// ----------------------------------------------------------------------------
// bti_divider
// restoring divider, one quotient bit a cycle, 64 by 33 bits unsigned
// ----------------------------------------------------------------------------
module bti_divider
  import bti_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [32:0] divisor,
  output logic [63:0] quotient,
  output div_ctl_t    ctl
);
  logic [63:0] quo;
  logic [33:0] rem;
  logic [32:0] dvs;
  logic [6:0]  cnt;
  logic        busy;
  logic        done;
  logic [33:0] trial;
  logic [33:0] shifted;

  always_comb begin
    shifted = {rem[32:0], quo[63]};
    trial   = shifted - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 7'd64;
      end else if (busy) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (!trial[33]) begin
        rem <= trial;
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= shifted;
        quo <= {quo[62:0], 1'b0};
      end
    end
  end

  assign quotient  = quo;
  assign ctl.start = start;
  assign ctl.busy  = busy;
  assign ctl.done  = done;
endmodule

// ----- rtl/core/bti_table_mem.sv -----
// ----------------------------------------------------------------------------
// bti_table_mem
// breakpoint store, one write and one registered read port
// ----------------------------------------------------------------------------
module bti_table_mem
  import bti_pkg::*;
#(
  parameter int TableDepth = DefTableDepth,
  localparam int AW = $clog2(TableDepth)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [63:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [63:0]   rdata
);
  logic [63:0] mem [TableDepth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/core/breakpoint_table_interpolator_core.sv -----
// ----------------------------------------------------------------------------
// breakpoint_table_interpolator_core
// piecewise linear lookup table with sorted insert and binary search
// ----------------------------------------------------------------------------
// Holds up to TableDepth (x, y) breakpoints in signed Q16.16, sorted by x.
// One beat is taken at a time; the result beat follows and the input is not
// ready until it has been taken. A load shifts larger entries up one place
// through the single memory, one read and one write per moved entry. A query
// runs a binary search (log2 of the count steps), fetches the bracketing pair
// and, in linear mode, runs a 64-step bit-serial divide. No clearing pass
// after reset.
module breakpoint_table_interpolator_core
  import bti_pkg::*;
#(
  parameter int TableDepth = DefTableDepth
) (
  input  logic       clk,
  input  logic       rst,
  bti_in_if.sink     in_ch,
  bti_out_if.source  out_ch,
  bti_cfg_if.sink    cfg
);
`include "breakpoint_table_interpolator_core_macros.svh"
  localparam int AW = $clog2(TableDepth);
  localparam int CW = $clog2(TableDepth + 1);

  state_t state, state_next;

  logic          interp_mode;
  logic [CW-1:0] point_count;
  logic signed [31:0] qx, qy;
  logic [CW-1:0] pos;       // insert position / scan
  logic [CW-1:0] left, right;
  logic signed [31:0] x1, y1, x2, y2;
  logic signed [31:0] res;
  logic [1:0]    res_st;
  logic          fetch_second;
  logic signed [33:0] diffy;
  logic [63:0]   prod;

  // memory
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [63:0]   wdata, rdata;
  logic signed [31:0] rd_x, rd_y;
  logic [CW-1:0] center;

  assign rd_x = rdata[63:32];
  assign rd_y = rdata[31:0];
  assign center = CW'(({1'b0, left} + {1'b0, right}) >> 1);

  bti_table_mem #(.TableDepth(TableDepth)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // divider
  logic        div_start;
  logic [63:0] quotient;
  div_ctl_t    div_ctl;
  logic [32:0] dx;
  logic [32:0] ax;
  logic [32:0] ady;

  assign dx = 33'($signed({x2[31], x2}) - $signed({x1[31], x1}));
  assign ax = 33'($signed({qx[31], qx}) - $signed({x1[31], x1}));
  assign ady = diffy[33] ? 33'(-diffy) : 33'(diffy);

  // product goes straight into the divider's dividend register
  assign prod = 64'(ax) * 64'(ady);

  bti_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(prod), .divisor(dx),
    .quotient(quotient), .ctl(div_ctl)
  );

  assign cfg.ready   = (state == S_IDLE);
  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = (state == S_OUT);
  assign out_ch.result_value = res;
  assign out_ch.status = res_st;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_ch.valid) begin
          state_next = S_DONE;
          if (in_ch.cmd == CMD_LOAD && point_count < CW'(TableDepth)) begin
            state_next = (point_count == '0) ? S_INS_WR : S_INS_RD;
          end else if (in_ch.cmd == CMD_QUERY && point_count != '0) begin
            state_next = S_SRCH_RD;
          end
        end
      end
      S_INS_RD:  state_next = S_INS_CMP;
      S_INS_CMP: begin
        if (rd_x > qx) begin
          state_next = (pos == CW'(1)) ? S_INS_WR : S_INS_RD;
        end else begin
          state_next = S_INS_WR;
        end
      end
      S_INS_WR:  state_next = S_OUT;
      S_SRCH_RD: state_next = (right - left > CW'(1)) ? S_SRCH_CMP : S_FETCH;
      S_SRCH_CMP: state_next = S_SRCH_RD;
      S_FETCH:   state_next = S_FETCH_W;
      S_FETCH_W: state_next = fetch_second ? S_MUL : S_FETCH;
      // nearest mode, clamps and equal x finish without the divider
      S_MUL:     state_next = div_start ? S_DIV : S_OUT;
      S_DIV:     state_next = div_ctl.done ? S_OUT : S_DIV;
      S_DONE:    state_next = S_OUT;
      S_OUT:     state_next = out_ch.ready ? S_IDLE : S_OUT;
      default:   state_next = S_IDLE;
    endcase
  end

  // memory and divider control
  always_comb begin
    we    = 1'b0;
    waddr = pos[AW-1:0];
    wdata = {qx, qy};
    raddr = pos[AW-1:0] - AW'(1);
    div_start = 1'b0;
    unique case (state)
      S_INS_CMP: begin
        if (rd_x > qx) begin
          we    = 1'b1;
          wdata = rdata;
        end
      end
      S_INS_WR:  we = 1'b1;
      S_SRCH_RD: raddr = center[AW-1:0];
      S_FETCH:   raddr = fetch_second ? right[AW-1:0] : left[AW-1:0];
      S_MUL:     div_start = interp_mode && (dx != '0) &&
                             !(qx < x1) && !(qx > x2);
      default: ;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      interp_mode <= 1'b0;
      point_count <= '0;
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.ready) begin
        interp_mode <= cfg.data;
      end
      if (state == S_INS_WR) begin
        point_count <= point_count + CW'(1);
      end
      if (in_ch.valid && in_ch.ready && in_ch.cmd == CMD_CLEAR) begin
        point_count <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        qx     <= in_ch.in_x;
        qy     <= in_ch.in_y;
        pos    <= point_count;
        left   <= '0;
        right  <= point_count - CW'(1);
        fetch_second <= 1'b0;
        res    <= '0;
        res_st <= ST_OK;
        if (in_ch.cmd == CMD_LOAD && point_count >= CW'(TableDepth)) begin
          res_st <= ST_FULL;
        end
        if (in_ch.cmd == CMD_QUERY && point_count == '0) begin
          res_st <= ST_EMPTY;
        end
      end
      S_INS_CMP: begin
        if (rd_x > qx) begin
          pos <= pos - CW'(1);
        end
      end
      S_SRCH_CMP: begin
        if (rd_x > qx) begin
          right <= center;
        end else begin
          left <= center;
        end
      end
      S_FETCH_W: begin
        if (!fetch_second) begin
          x1 <= rd_x;
          y1 <= rd_y;
          fetch_second <= 1'b1;
        end else begin
          x2 <= rd_x;
          y2 <= rd_y;
        end
      end
      S_MUL: begin
        // clamps: search leaves left=0 below range and right=last above
        if (!interp_mode) begin
          res <= ($signed({qx[31], qx}) - $signed({x1[31], x1}) <
                  $signed({x2[31], x2}) - $signed({qx[31], qx})) ? y1 : y2;
        end else if (qx < x1) begin
          res <= y1;
        end else if (qx > x2) begin
          res <= y2;
        end else begin
          res <= y1;
        end
      end
      S_DIV: begin
        if (div_ctl.done) begin
          if (diffy[33]) begin
            res <= sat_sub(y1, quotient);
          end else begin
            res <= sat_add(y1, quotient);
          end
        end
      end
      default: ;
    endcase
  end

  assign diffy = 34'($signed(y2)) - 34'($signed(y1));

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic [63:0] q);
    logic signed [65:0] s;
    s = 66'($signed(a)) + $signed({2'b00, q});
    if (s > 66'sd2147483647) return 32'sh7fffffff;
    if (s < -66'sd2147483648) return 32'sh80000000;
    return s[31:0];
  endfunction

  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                 input logic [63:0] q);
    logic signed [65:0] s;
    s = 66'($signed(a)) - $signed({2'b00, q});
    if (s > 66'sd2147483647) return 32'sh7fffffff;
    if (s < -66'sd2147483648) return 32'sh80000000;
    return s[31:0];
  endfunction

  `BTI_ASSERT(a_count_range, clk, rst, point_count <= CW'(TableDepth), "count over depth")
  `BTI_ASSERT(a_search_order, clk, rst, (state == S_SRCH_RD) |-> (left <= right), "search crossed")
  `BTI_ASSERT(a_div_only_linear, clk, rst, div_start |-> interp_mode, "divide in nearest mode")
  `BTI_ASSERT(a_out_hold, clk, rst, (out_ch.valid && !out_ch.ready) |=> out_ch.valid, "beat dropped")
endmodule
